@@ src/fbpa_pkg.sv @@
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

  // Default pool geometry
  localparam int unsigned NUM_BLOCKS_DEF  = 32;
  localparam int unsigned BLOCK_WORDS_DEF = 32;

  // Operation codes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Status codes
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  // Input transaction
  typedef struct packed {
    logic        opcode;
    logic [31:0] release_address;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic [31:0] block_address;
    logic        status;
  } rsp_t;

  // Controls broadcast to every stack cell
  typedef struct packed {
    logic load;      // refill the stack with its reset contents
    logic push;      // shift towards the bottom, new index enters the top
    logic pop;       // shift towards the top
    logic scan_clr;  // clear the match chain
    logic scan_en;   // advance the match chain by one cell
  } cell_ctrl_t;

endpackage

@@ src/fbpa_cell.sv @@
// One stack cell: holds one free index, its valid bit and a match flag.
module fbpa_cell #(
  parameter int unsigned             IDX_W    = 5,
  parameter logic [IDX_W-1:0]        INIT_VAL = '0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbpa_pkg::cell_ctrl_t ctrl_i,
  input  logic [IDX_W-1:0]    idx_i,
  // neighbour nearer the top (feeds a push)
  input  logic [IDX_W-1:0]    up_entry_i,
  input  logic                up_valid_i,
  // neighbour nearer the bottom (feeds a pop and the match chain)
  input  logic [IDX_W-1:0]    dn_entry_i,
  input  logic                dn_valid_i,
  input  logic                dn_hit_i,
  output logic [IDX_W-1:0]    entry_o,
  output logic                valid_o,
  output logic                hit_o
);

  logic [IDX_W-1:0] entry_q, entry_d;
  logic             valid_q, valid_d;
  logic             hit_q, hit_d;

  // Stack movement
  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.load) begin
      entry_d = INIT_VAL;
      valid_d = 1'b1;
    end else if (ctrl_i.push) begin
      entry_d = up_entry_i;
      valid_d = up_valid_i;
    end else if (ctrl_i.pop) begin
      entry_d = dn_entry_i;
      valid_d = dn_valid_i;
    end
  end

  // Match flag travels towards the top, picking up this cell's compare
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.scan_clr) begin
      hit_d = 1'b0;
    end else if (ctrl_i.scan_en) begin
      hit_d = dn_hit_i | (valid_q && (entry_q == idx_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= INIT_VAL;
      valid_q <= 1'b1;
      hit_q   <= 1'b0;
    end else begin
      entry_q <= entry_d;
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

@@ src/fixed_block_pool_allocator.sv @@
// Top level of the fixed block pool allocator: control, reciprocal divider and cell chain.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+------------------------
//  command   | in        | start / busy                  | req_i  (fbpa_pkg::req_t)
//  result    | out       | result_valid_o, one cycle     | rsp_o  (fbpa_pkg::rsp_t)
//  config    | in/out    | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// A request, or a release outside the pool or onto a full stack: result next cycle, busy low.
// Other releases hold busy through one reciprocal multiply, then one alignment check
// (a misaligned address answers here), then a scan as the match flag ripples up the chain.
// Reset and a write to pool_base refill the stack with 0..NUM_BLOCKS-1.
// The receiver cannot stall; each result is shown for exactly one cycle.
module fixed_block_pool_allocator #(
  parameter int unsigned NUM_BLOCKS  = fbpa_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_WORDS = fbpa_pkg::BLOCK_WORDS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // command transaction
  input  logic           start,
  output logic           busy,
  input  fbpa_pkg::req_t req_i,
  // result transaction
  output logic           result_valid_o,
  output fbpa_pkg::rsp_t rsp_o,
  // configuration port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int unsigned IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned BLK_B   = BLOCK_WORDS * 4;
  localparam int unsigned LIMIT   = NUM_BLOCKS * BLK_B;
  localparam int unsigned OFF_W   = $clog2(LIMIT);
  localparam logic [31:0] HDR_B   = 32'((NUM_BLOCKS + 1) * 4);
  localparam logic [31:0] BLK_B32 = 32'(BLK_B);
  localparam logic [31:0] LIM32   = 32'(LIMIT);
  // Reciprocal of the block size, exact for every offset below 2^OFF_W
  localparam int unsigned     BLK_LG  = $clog2(BLK_B);
  localparam int unsigned     SHIFT   = OFF_W + BLK_LG;
  localparam int unsigned     RCP_W   = OFF_W + 2;
  localparam int unsigned     PROD_W  = OFF_W + RCP_W;
  localparam longint unsigned RCP_VAL = ((64'd1 << SHIFT) + BLK_B - 1) / BLK_B;
  localparam logic [RCP_W-1:0] RCP    = RCP_W'(RCP_VAL);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_CHK  = 4'b0100,
    S_SCAN = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [31:0]          base_q;
  logic [OFF_W-1:0]     off_q, off_d;
  logic [IDX_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 out_vld_q, out_vld_d;
  fbpa_pkg::rsp_t       out_q, out_d;
  fbpa_pkg::cell_ctrl_t ctrl;

  logic [IDX_W-1:0]      entry_w [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid_w;
  logic [NUM_BLOCKS-1:0] hit_w;

  logic              cfg_wr;
  logic [31:0]       req_addr;
  logic [31:0]       rel_off;
  logic [31:0]       off_ext;
  logic [31:0]       chk_off;
  logic [PROD_W-1:0] prod;

  // Configuration port
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? base_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'h0;
    end else if (cfg_wr) begin
      base_q <= pwdata;
    end
  end

  // Address arithmetic
  assign req_addr = base_q + HDR_B + (32'(entry_w[0]) * BLK_B32);
  assign rel_off  = req_i.release_address - base_q - HDR_B;
  assign off_ext  = 32'(off_q);
  assign prod     = PROD_W'(off_q) * PROD_W'(RCP);
  assign chk_off  = 32'(quo_q) * BLK_B32;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    off_d     = off_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    out_vld_d = 1'b0;
    out_d     = out_q;
    ctrl      = '0;
    ctrl.load = cfg_wr;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_i.opcode == fbpa_pkg::OP_REQUEST) begin
            out_vld_d = 1'b1;
            if (valid_w[0]) begin
              out_d.block_address = req_addr;
              out_d.status        = fbpa_pkg::ST_OK;
              ctrl.pop            = 1'b1;
            end else begin
              out_d.block_address = 32'h0;
              out_d.status        = fbpa_pkg::ST_ERR;
            end
          end else if ((rel_off >= LIM32) || valid_w[NUM_BLOCKS-1]) begin
            out_vld_d           = 1'b1;
            out_d.block_address = 32'h0;
            out_d.status        = fbpa_pkg::ST_ERR;
          end else begin
            off_d         = rel_off[OFF_W-1:0];
            quo_d         = '0;
            cnt_d         = '0;
            ctrl.scan_clr = 1'b1;
            state_d       = S_DIV;
          end
        end
      end
      S_DIV: begin
        quo_d   = IDX_W'(prod >> SHIFT);
        state_d = S_CHK;
      end
      S_CHK: begin
        // only an exact block start may be released
        if (off_ext != chk_off) begin
          out_vld_d           = 1'b1;
          out_d.block_address = 32'h0;
          out_d.status        = fbpa_pkg::ST_ERR;
          state_d             = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q == CNT_W'(NUM_BLOCKS)) begin
          out_vld_d           = 1'b1;
          out_d.block_address = 32'h0;
          if (hit_w[0]) begin
            out_d.status = fbpa_pkg::ST_ERR;
          end else begin
            out_d.status = fbpa_pkg::ST_OK;
            ctrl.push    = 1'b1;
          end
          state_d = S_IDLE;
        end else begin
          ctrl.scan_en = 1'b1;
          cnt_d        = cnt_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = out_vld_q;
  assign rsp_o          = out_q;

  // Cell chain: cell 0 is the top of the stack
  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
    logic [IDX_W-1:0] up_entry, dn_entry;
    logic             up_valid, dn_valid, dn_hit;

    if (k == 0) begin : g_top
      assign up_entry = quo_q;
      assign up_valid = 1'b1;
    end else begin : g_mid_up
      assign up_entry = entry_w[k-1];
      assign up_valid = valid_w[k-1];
    end

    if (k == NUM_BLOCKS - 1) begin : g_bottom
      assign dn_entry = '0;
      assign dn_valid = 1'b0;
      assign dn_hit   = 1'b0;
    end else begin : g_mid_dn
      assign dn_entry = entry_w[k+1];
      assign dn_valid = valid_w[k+1];
      assign dn_hit   = hit_w[k+1];
    end

    fbpa_cell #(
      .IDX_W    (IDX_W),
      .INIT_VAL (IDX_W'(NUM_BLOCKS - 1 - k))
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .idx_i      (quo_q),
      .up_entry_i (up_entry),
      .up_valid_i (up_valid),
      .dn_entry_i (dn_entry),
      .dn_valid_i (dn_valid),
      .dn_hit_i   (dn_hit),
      .entry_o    (entry_w[k]),
      .valid_o    (valid_w[k]),
      .hit_o      (hit_w[k])
    );
  end

`ifndef SYNTH
  // A pop only ever takes a live entry off the top
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |-> (valid_w[0] && !ctrl.push))
    else $error("pop issued on an empty stack");

  // A push never overflows the bottom cell
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |-> !valid_w[NUM_BLOCKS-1])
    else $error("push issued on a full stack");

  // Every result follows an accepted transaction or the end of a busy spell
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a transaction");

  // The sequencer only leaves idle on an accepted release
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> ($past(start) && ($past(req_i.opcode) == fbpa_pkg::OP_RELEASE)))
    else $error("busy raised without a release");
`endif

endmodule

@@ test/fixed_block_pool_allocator_tb.sv @@
// Self-checking testbench of the fixed block pool allocator: directed and random commands.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;

  localparam int unsigned NBLK      = fbpa_pkg::NUM_BLOCKS_DEF;
  localparam int unsigned BLK_BYTES = fbpa_pkg::BLOCK_WORDS_DEF * 4;
  localparam logic [31:0] HDR_BYTES = (NBLK + 1) * 4;

  // Register byte addresses; index 1 is not implemented
  localparam logic [2:0] REG_POOL_BASE = 3'd0;
  localparam logic [2:0] REG_SPARE     = 3'd4;

  localparam int unsigned PHASE_ITEMS = 170;
  localparam int unsigned SEG_ITEMS   = 34;

  // Free stack predictor and store of expected answers
  class pool_scoreboard;
    logic [31:0]    base;
    int unsigned    stack [NBLK];
    int unsigned    count;
    fbpa_pkg::rsp_t answer_q [$];
    int unsigned    errors;

    function new();
      base   = '0;
      errors = 0;
      refill();
    endfunction

    function void refill();
      for (int unsigned i = 0; i < NBLK; i++) stack[i] = i;
      count = NBLK;
    endfunction

    function void set_base(logic [31:0] b);
      base = b;
      refill();
    endfunction

    function logic [31:0] addr_of(int unsigned idx);
      return base + HDR_BYTES + idx * BLK_BYTES;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // Predict the answer to an accepted command and queue it
    function fbpa_pkg::rsp_t note_command(fbpa_pkg::req_t cmd);
      fbpa_pkg::rsp_t r;
      logic [31:0]    off;
      int unsigned    idx;
      bit             dup;
      r.block_address = '0;
      r.status        = fbpa_pkg::ST_ERR;
      if (cmd.opcode == fbpa_pkg::OP_REQUEST) begin
        if (count != 0) begin
          count--;
          r.block_address = addr_of(stack[count]);
          r.status        = fbpa_pkg::ST_OK;
        end
      end else begin
        off = cmd.release_address - base - HDR_BYTES;
        idx = off / BLK_BYTES;
        if ((off % BLK_BYTES) == 0 && idx < NBLK && count < NBLK) begin
          dup = 1'b0;
          for (int unsigned i = 0; i < count; i++) if (stack[i] == idx) dup = 1'b1;
          if (!dup) begin
            stack[count] = idx;
            count++;
            r.status = fbpa_pkg::ST_OK;
          end
        end
      end
      answer_q.push_back(r);
      return r;
    endfunction

    // Compare one answer with the oldest prediction
    function void check_result(fbpa_pkg::rsp_t got);
      fbpa_pkg::rsp_t want;
      if (answer_q.size() == 0) begin
        report($sformatf("unexpected answer: addr %h st %0d", got.block_address, got.status));
        return;
      end
      want = answer_q.pop_front();
      if (got.block_address !== want.block_address)
        report($sformatf("block_address mismatch: exp %h got %h",
                         want.block_address, got.block_address));
      if (got.status !== want.status)
        report($sformatf("status bit mismatch: exp %0d got %0d", want.status, got.status));
    endfunction
  endclass

  logic           clk_i   = 1'b0;
  logic           rst_ni  = 1'b0;
  logic           start   = 1'b0;
  logic           busy;
  fbpa_pkg::req_t req_i   = '0;
  logic           result_valid_o;
  fbpa_pkg::rsp_t rsp_o;
  logic           psel    = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite  = 1'b0;
  logic [2:0]     paddr   = '0;
  logic [31:0]    pwdata  = '0;
  logic [31:0]    prdata;
  logic           pready;

  pool_scoreboard sb = new();
  logic [31:0]    granted_q [$];  // blocks the predictor says are handed out
  bit             no_idle = 1'b0;

  fixed_block_pool_allocator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Answer monitor
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) sb.check_result(rsp_o);
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Issue one command transaction after a random gap
  task automatic send_command(input logic op, input logic [31:0] addr);
    fbpa_pkg::req_t cmd;
    fbpa_pkg::rsp_t r;
    int unsigned    gap;
    int             hit;
    cmd.opcode          = op;
    cmd.release_address = addr;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= cmd;
    do @(posedge clk_i); while (busy !== 1'b0);
    r = sb.note_command(cmd);
    if (r.status == fbpa_pkg::ST_OK) begin
      if (op == fbpa_pkg::OP_REQUEST) begin
        granted_q.push_back(r.block_address);
      end else begin
        hit = -1;
        for (int k = 0; k < granted_q.size(); k++) if (hit < 0 && granted_q[k] == addr) hit = k;
        if (hit >= 0) granted_q.delete(hit);
      end
    end
  endtask

  // Stop sending and wait until every answer is in
  task automatic drain();
    start <= 1'b0;
    while (sb.answer_q.size() != 0 || busy !== 1'b0) @(posedge clk_i);
  endtask

  // One APB transaction: setup then access phase, then back to idle
  task automatic reg_access(input bit wr, input logic [2:0] a, input logic [31:0] d,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd      = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr && a == REG_POOL_BASE) sb.set_base(d);
    @(posedge clk_i);
  endtask

  // Write pool_base and read it back
  task automatic set_pool_base(input logic [31:0] b);
    logic [31:0] rd;
    drain();
    reg_access(1'b1, REG_POOL_BASE, b, rd);
    reg_access(1'b0, REG_POOL_BASE, '0, rd);
    if (rd !== sb.base) sb.report($sformatf("pool_base readback: exp %h got %h", sb.base, rd));
    granted_q.delete();
  endtask

  // Write the unimplemented register; must not disturb anything
  task automatic poke_spare();
    logic [31:0] rd;
    drain();
    reg_access(1'b1, REG_SPARE, $urandom(), rd);
  endtask

  // Random command, mostly well-formed use of the pool
  task automatic random_command(input int unsigned p_req);
    int unsigned roll;
    logic [31:0] a;
    roll = $urandom_range(0, 99);
    if (roll < p_req) begin
      send_command(fbpa_pkg::OP_REQUEST, $urandom());
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60 && granted_q.size() > 0)
        a = granted_q[$urandom_range(0, granted_q.size() - 1)];
      else if (roll < 75)
        a = sb.addr_of($urandom_range(0, NBLK - 1));  // often still free
      else if (roll < 88)
        a = sb.addr_of($urandom_range(0, NBLK + 1)) - BLK_BYTES
            + $urandom_range(0, 2 * BLK_BYTES);
      else
        a = $urandom();
      send_command(fbpa_pkg::OP_RELEASE, a);
    end
  endtask

  initial begin
    logic [31:0] bases [6];
    logic [31:0] rd;
    int unsigned p_req;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of pool_base
    reg_access(1'b0, REG_POOL_BASE, '0, rd);
    if (rd !== 32'h0) sb.report($sformatf("pool_base after reset: exp 0 got %h", rd));

    // Directed: full stack, double release, misaligned, out of range, wrap
    send_command(fbpa_pkg::OP_RELEASE, sb.addr_of(0));
    send_command(fbpa_pkg::OP_REQUEST, 32'hFFFF_FFFF);
    send_command(fbpa_pkg::OP_REQUEST, 32'h0000_0000);
    send_command(fbpa_pkg::OP_RELEASE, sb.addr_of(NBLK - 1));
    send_command(fbpa_pkg::OP_RELEASE, sb.addr_of(NBLK - 1));
    send_command(fbpa_pkg::OP_RELEASE, sb.addr_of(NBLK - 2) + 1);
    send_command(fbpa_pkg::OP_RELEASE, sb.addr_of(NBLK - 2) + BLK_BYTES / 2);
    send_command(fbpa_pkg::OP_RELEASE, sb.addr_of(0) - BLK_BYTES);
    send_command(fbpa_pkg::OP_RELEASE, sb.addr_of(NBLK));
    send_command(fbpa_pkg::OP_RELEASE, 32'h0000_0000);
    send_command(fbpa_pkg::OP_RELEASE, 32'hFFFF_FFFF);
    send_command(fbpa_pkg::OP_RELEASE, sb.addr_of(NBLK - 2));
    send_command(fbpa_pkg::OP_REQUEST, 32'hAAAA_AAAA);
    send_command(fbpa_pkg::OP_REQUEST, 32'h5555_5555);
    send_command(fbpa_pkg::OP_REQUEST, 32'h0000_0000);
    poke_spare();
    send_command(fbpa_pkg::OP_RELEASE, granted_q[0]);
    send_command(fbpa_pkg::OP_REQUEST, 32'h0000_0000);
    set_pool_base(32'hFFFF_FFFF);
    send_command(fbpa_pkg::OP_REQUEST, 32'h0000_0000);
    send_command(fbpa_pkg::OP_REQUEST, 32'hFFFF_FFFF);
    send_command(fbpa_pkg::OP_RELEASE, granted_q[0]);
    send_command(fbpa_pkg::OP_RELEASE, 32'h0000_0084);  // block 0 under the old base
    send_command(fbpa_pkg::OP_RELEASE, sb.addr_of(NBLK - 1));

    // Random phases over several base settings
    bases[0] = 32'hFFFF_FFFF;
    bases[1] = 32'h0000_0000;
    bases[2] = $urandom();
    bases[3] = 32'hFFFF_F800;
    bases[4] = $urandom();
    bases[5] = 32'h7FFF_FF80;
    foreach (bases[ph]) begin
      set_pool_base(bases[ph]);
      if (ph % 2 == 1) poke_spare();
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (n % SEG_ITEMS == 0) begin
          // first segment drains the pool past empty
          case ($urandom_range(0, 2))
            0: p_req = 20;
            1: p_req = 50;
            default: p_req = 85;
          endcase
          if (n == 0) p_req = 100;
          no_idle = ($urandom_range(0, 3) == 0);
        end
        random_command(p_req);
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.answer_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ fixed_block_pool_allocator.f @@
src/fbpa_pkg.sv
src/fbpa_cell.sv
src/fixed_block_pool_allocator.sv
test/fixed_block_pool_allocator_tb.sv
